[src/cft_pkg.sv]
package cft_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;

  // Parser modes, one-hot
  typedef enum logic [7:0] {
    ModeStart     = 8'b0000_0001,
    ModePlain     = 8'b0000_0010,
    ModeQuoted    = 8'b0000_0100,
    ModeQuoteSeen = 8'b0000_1000,
    ModeAfterCr   = 8'b0001_0000,
    ModeErrUnterm = 8'b0010_0000,
    ModeErrAfterQ = 8'b0100_0000,
    ModeErrStray  = 8'b1000_0000
  } mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KindData    = 2'd0,
    KindEnd     = 2'd1,
    KindNoField = 2'd2,
    KindError   = 2'd3
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrUnterm  = 2'd1,
    ErrAfterQ  = 2'd2,
    ErrStray   = 2'd3
  } err_e;

  // Outcome of one parser step
  typedef struct packed {
    logic       res_valid;
    kind_e      kind;
    logic [7:0] data_byte;
    logic       rec_end;
    err_e       error_code;
    mode_e      next_mode;
  } step_t;

endpackage

[src/cft_if.sv]
interface cft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface cft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       rec_end;
  logic [1:0] error_code;

  modport source (output valid, output kind, output data_byte, output rec_end,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input data_byte, input rec_end,
                  input error_code, output ready);
endinterface

[src/cft_step.sv]
module cft_step (
  input  cft_pkg::mode_e mode_i,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_input_i,
  output cft_pkg::step_t step_o
);
  import cft_pkg::*;

  logic is_comma, is_quote, is_lf, is_cr, is_delim;

  assign is_comma = (in_byte_i == CharComma);
  assign is_quote = (in_byte_i == CharQuote);
  assign is_lf    = (in_byte_i == CharLf);
  assign is_cr    = (in_byte_i == CharCr);
  assign is_delim = is_comma || is_lf || is_cr;

  always_comb begin
    step_o            = '0;
    step_o.kind       = KindData;
    step_o.error_code = ErrNone;
    step_o.next_mode  = mode_i;

    case (mode_i)
      ModeStart, ModeAfterCr: begin
        if (mode_i == ModeAfterCr && !end_of_input_i && is_lf) begin
          // swallow LF of CR LF
          step_o.next_mode = ModeStart;
        end else if (end_of_input_i) begin
          step_o.res_valid = 1'b1;
          step_o.kind      = KindNoField;
          step_o.next_mode = ModeStart;
        end else if (is_quote) begin
          step_o.next_mode = ModeQuoted;
        end else if (is_delim) begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindEnd;
          step_o.rec_end    = !is_comma;
          step_o.next_mode  = is_cr ? ModeAfterCr : ModeStart;
        end else begin
          step_o.res_valid = 1'b1;
          step_o.data_byte = in_byte_i;
          step_o.next_mode = ModePlain;
        end
      end
      ModePlain: begin
        if (end_of_input_i) begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindEnd;
          step_o.rec_end    = 1'b1;
          step_o.next_mode  = ModeStart;
        end else if (is_delim) begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindEnd;
          step_o.rec_end    = !is_comma;
          step_o.next_mode  = is_cr ? ModeAfterCr : ModeStart;
        end else if (is_quote) begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindError;
          step_o.error_code = ErrStray;
          step_o.next_mode  = ModeErrStray;
        end else begin
          step_o.res_valid = 1'b1;
          step_o.data_byte = in_byte_i;
        end
      end
      ModeQuoted: begin
        if (end_of_input_i) begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindError;
          step_o.error_code = ErrUnterm;
          step_o.next_mode  = ModeErrUnterm;
        end else if (is_quote) begin
          step_o.next_mode = ModeQuoteSeen;
        end else begin
          step_o.res_valid = 1'b1;
          step_o.data_byte = in_byte_i;
        end
      end
      ModeQuoteSeen: begin
        if (end_of_input_i) begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindEnd;
          step_o.rec_end    = 1'b1;
          step_o.next_mode  = ModeStart;
        end else if (is_quote) begin
          // doubled quote gives one literal quote
          step_o.res_valid = 1'b1;
          step_o.data_byte = CharQuote;
          step_o.next_mode = ModeQuoted;
        end else if (is_delim) begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindEnd;
          step_o.rec_end    = !is_comma;
          step_o.next_mode  = is_cr ? ModeAfterCr : ModeStart;
        end else begin
          step_o.res_valid  = 1'b1;
          step_o.kind       = KindError;
          step_o.error_code = ErrAfterQ;
          step_o.next_mode  = ModeErrAfterQ;
        end
      end
      ModeErrUnterm: begin
        step_o.res_valid  = 1'b1;
        step_o.kind       = KindError;
        step_o.error_code = ErrUnterm;
      end
      ModeErrAfterQ: begin
        step_o.res_valid  = 1'b1;
        step_o.kind       = KindError;
        step_o.error_code = ErrAfterQ;
      end
      ModeErrStray: begin
        step_o.res_valid  = 1'b1;
        step_o.kind       = KindError;
        step_o.error_code = ErrStray;
      end
      default: begin
        step_o.next_mode = ModeStart;
      end
    endcase
  end

endmodule

[src/csv_field_tokenizer_core.sv]
// CSV field tokenizer.
// in_ch carries one transaction per raw byte of the stream (in_byte), or an
// end-of-file marker (end_of_input set, in_byte ignored). out_ch carries at
// most one result per input transaction: a field content byte, a field end
// with a record-end flag, an end-without-field mark, or an error code.
// Quoted fields are handled, a doubled quote yields one quote byte, and the
// LF of a CR LF pair is swallowed without a result.
// A result appears on out_ch in the cycle after its input transaction is taken.
// Throughput: one input transaction per cycle while out_ch is not stalled; the
// rate is set by the single output register, refilled in the same cycle it drains.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the parser to field start. Errors are sticky until the next reset.
// When the receiver stalls, the output register holds its result and
// in_ch.ready drops, so no transaction is taken until the result leaves.
module csv_field_tokenizer_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  cft_in_if.sink         in_ch,
  cft_out_if.source      out_ch
);
  import cft_pkg::*;

  mode_e      mode_q, mode_d;
  step_t      step;
  logic       in_acc;
  logic       out_valid_q, out_valid_d;
  kind_e      kind_q;
  logic [7:0] data_q;
  logic       rec_q;
  err_e       err_q;

  cft_step u_step (
    .mode_i         (mode_q),
    .in_byte_i      (in_ch.in_byte),
    .end_of_input_i (in_ch.end_of_input),
    .step_o         (step)
  );

  // Take a new transaction whenever the output register is free or draining
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    if (in_acc) begin
      mode_d      = step.next_mode;
      out_valid_d = step.res_valid;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeStart;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load only when a result is produced
  always_ff @(posedge clk_i) begin
    if (in_acc && step.res_valid) begin
      kind_q <= step.kind;
      data_q <= step.data_byte;
      rec_q  <= step.rec_end;
      err_q  <= step.error_code;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.kind       = kind_q;
  assign out_ch.data_byte  = data_q;
  assign out_ch.rec_end    = rec_q;
  assign out_ch.error_code = err_q;

  // Error modes are sticky
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeErrUnterm || mode_q == ModeErrAfterQ || mode_q == ModeErrStray)
    |=> mode_q == $past(mode_q))
    else $error("error mode left without reset");

  // A stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  // Any input in an error mode yields an error result
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_q == ModeErrUnterm || mode_q == ModeErrAfterQ ||
                mode_q == ModeErrStray))
    |=> (out_valid_q && kind_q == KindError && err_q != ErrNone))
    else $error("missing sticky error result");

  // Only error results carry an error code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KindError) |-> err_q == ErrNone)
    else $error("error code on non-error result");

endmodule
